### rtl/ccrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccrs_pkg: shared types and constants
// Status codes, operation codes and sequencer states for the spline block.
// ----------------------------------------------------------------------------
package ccrs_pkg;

  localparam int CoordW = 32;
  localparam int ParamW = 24;
  localparam int FracW  = 16;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_EVAL   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ERROR = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_MOD,
    S_SQ,
    S_CUBE,
    S_WEIGHT,
    S_RD,
    S_MAC,
    S_ROUND,
    S_OUT
  } seq_state_t;

endpackage : ccrs_pkg
`default_nettype wire

### rtl/ccrs_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccrs_mul: shared registered multiplier
// One signed 33x33 product per cycle, result registered.
// ----------------------------------------------------------------------------
module ccrs_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule : ccrs_mul
`default_nettype wire

### rtl/ccrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccrs_div: restoring remainder unit
// Computes num mod den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccrs_div #(
  parameter int NumW = 32,
  parameter int DenW = 7
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [DenW-1:0]      rem
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] shreg;
  logic [DenW:0]   part;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {part[DenW-1:0], shreg[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        shreg <= num;
        part <= '0;
      end else if (busy) begin
        shreg <= shreg << 1;
        if (trial >= {1'b0, den}) part <= trial - {1'b0, den};
        else                      part <= trial;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = part[DenW-1:0];
endmodule : ccrs_div
`default_nettype wire

### rtl/closed_catmull_rom_spline_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closed_catmull_rom_spline_eval: closed-loop Catmull-Rom spline evaluator
// Appends 3D control points and evaluates the closed uniform spline.
// ----------------------------------------------------------------------------
// Append: the response is registered; m_tvalid rises in the cycle after acceptance.
// Evaluate order: scale, modulo (14 quotient bits), square, cube, weights, blend, out.
// Throughput: one append per cycle while m_tready is high; evaluates do not overlap.
// s_tready is low while an item is in work or while a result waits unaccepted.
// Reset (rst, synchronous) clears point count and control; point memory is not cleared.
module closed_catmull_rom_spline_eval
  import ccrs_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64], eval_param[119:96]
  input  wire logic [119:0] s_tdata,
  // operation
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], status[97:96], zero fill
  output logic [103:0]      m_tdata
);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int UW  = CW + ParamW - 1;
  localparam int IW  = UW - FracW;

  logic [CoordW-1:0] mem_x [MAX_POINTS];
  logic [CoordW-1:0] mem_y [MAX_POINTS];
  logic [CoordW-1:0] mem_z [MAX_POINTS];

  seq_state_t state, state_next;
  logic [CW-1:0]  count;
  logic [ParamW-2:0] tpar;
  logic [FracW-1:0] s;
  logic [FracW:0] s2, s3;
  logic signed [19:0] w [4];
  logic [AW-1:0]  base, ridx;
  logic [1:0]     ksel, kcnt;
  logic [1:0]     axis;
  logic signed [CoordW-1:0] rd;
  logic signed [65:0] acc;
  logic signed [31:0] res [3];
  logic           sat;
  logic           mul_pend;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic           div_start, div_done;
  logic [CW-1:0]  rem;
  logic           ovalid;
  logic [1:0]     ostat;
  logic [2:0]     wstep;

  ccrs_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // integer part of t * count is taken straight from the product register
  ccrs_div #(.NumW(IW), .DenW(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(mp[UW-1:FracW]),
    .den(count), .done(div_done), .rem(rem)
  );

  assign s_tready = (state == S_IDLE) && !(ovalid && !m_tready);
  assign m_tvalid = ovalid;
  assign m_tdata  = {6'd0, ostat, res[2], res[1], res[0]};

  // next index = (base + k) mod count, count <= MAX_POINTS, k <= 3
  logic [CW:0] isum;
  assign isum = {1'b0, CW'(base)} + {1'b0, CW'(kcnt)};
  always_comb begin
    logic [CW:0] r;
    r = isum;
    if (r >= {1'b0, count}) r = r - {1'b0, count};
    if (r >= {1'b0, count}) r = r - {1'b0, count};
    if (r >= {1'b0, count}) r = r - {1'b0, count};
    ridx = AW'(r);
  end

  // weight evaluation, exact combination
  logic signed [19:0] ss, ss2, ss3;
  assign ss  = 20'(s);
  assign ss2 = 20'(s2);
  assign ss3 = 20'(s3);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ma = '0;
    mb = '0;
    unique case (state)
      S_IDLE:   if (s_tvalid && s_tready && s_tuser == OP_EVAL) begin
        if (!s_tdata[119] && count != '0) state_next = S_SCALE;
      end
      S_SCALE: begin
        ma = 33'(tpar);
        mb = 33'(count);
        state_next = S_MOD;
      end
      S_MOD: begin
        if (div_done) state_next = S_SQ;
        if (mul_pend) div_start = 1'b1;
      end
      S_SQ: begin
        ma = 33'(s);
        mb = 33'(s);
        state_next = S_CUBE;
      end
      S_CUBE: begin
        // full s*s times s keeps the cube exact
        if (wstep == 3'd0) begin
          ma = {1'b0, mp[31:0]};
          mb = 33'(s);
        end
        if (wstep == 3'd1) state_next = S_WEIGHT;
      end
      S_WEIGHT: state_next = S_RD;
      S_RD:     state_next = S_MAC;
      S_MAC: begin
        ma = 33'(rd);
        mb = 33'(w[ksel]);
        if (ksel == 2'd3) state_next = S_ROUND;
        else state_next = S_RD;
      end
      S_ROUND: if (!mul_pend) begin
        if (axis == 2'd2) state_next = S_OUT;
        else state_next = S_RD;
      end
      S_OUT: if (!(ovalid && !m_tready)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic signed [65:0] rsum;
  logic signed [48:0] rsh;
  assign rsum = acc + 66'sd65536;
  assign rsh  = 49'(rsum >>> 17);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser == OP_APPEND && count < CW'(MAX_POINTS)) begin
      mem_x[AW'(count)] <= s_tdata[31:0];
      mem_y[AW'(count)] <= s_tdata[63:32];
      mem_z[AW'(count)] <= s_tdata[95:64];
    end
    if (state == S_RD) begin
      unique case (axis)
        2'd0:    rd <= mem_x[ridx];
        2'd1:    rd <= mem_y[ridx];
        default: rd <= mem_z[ridx];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
      mul_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (ovalid && m_tready) ovalid <= 1'b0;
      mul_pend <= (state == S_SCALE) || (state == S_MAC);
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          tpar <= s_tdata[118:96];
          res[0] <= '0; res[1] <= '0; res[2] <= '0;
          sat <= 1'b0;
          axis <= '0;
          kcnt <= '0;
          ksel <= '0;
          acc <= '0;
          wstep <= '0;
          if (s_tuser == OP_APPEND) begin
            ovalid <= 1'b1;
            if (count < CW'(MAX_POINTS)) begin
              count <= count + 1'b1;
              ostat <= ST_OK;
            end else ostat <= ST_FULL;
          end else if (s_tdata[119] || count == '0) begin
            ovalid <= 1'b1;
            ostat <= ST_ERROR;
          end
        end
        S_MOD: begin
          if (mul_pend) s <= mp[FracW-1:0];
          if (div_done) base <= AW'(rem);
        end
        S_CUBE: begin
          wstep <= wstep + 1'b1;
          if (wstep == 3'd0) s2 <= 17'(mp[31:16]);
          if (wstep == 3'd1) s3 <= 17'(mp[47:32]);
        end
        S_WEIGHT: begin
          w[0] <= -ss3 + (ss2 <<< 1) - ss;
          w[1] <= (ss3 <<< 1) + ss3 - (ss2 <<< 2) - ss2 + 20'sd131072;
          w[2] <= -((ss3 <<< 1) + ss3) + (ss2 <<< 2) + ss;
          w[3] <= ss3 - ss2;
          kcnt <= 2'd0;
        end
        S_RD: begin
          kcnt <= kcnt + 1'b1;
          if (mul_pend) acc <= acc + mp;
        end
        S_MAC: begin
          ksel <= ksel + 1'b1;
          if (mul_pend) acc <= acc + mp;
        end
        S_ROUND: begin
          if (mul_pend) acc <= acc + mp;
          else begin
            if (rsh > 49'sd2147483647) begin
              res[axis] <= 32'sh7fffffff; sat <= 1'b1;
            end else if (rsh < -49'sd2147483648) begin
              res[axis] <= 32'sh80000000; sat <= 1'b1;
            end else res[axis] <= rsh[31:0];
            acc <= '0;
            axis <= axis + 1'b1;
            kcnt <= 2'd0;
            ksel <= '0;
          end
        end
        S_OUT: if (!(ovalid && !m_tready)) begin
          ovalid <= 1'b1;
          ostat <= sat ? ST_SAT : ST_OK;
        end
        default: ;
      endcase
    end
  end

  // kcnt counts reads from base and restarts at 0 for each axis; the product of
  // one read lands in acc during the following read or the round step

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS)) else $error("count overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output lost");
`endif
endmodule : closed_catmull_rom_spline_eval
`default_nettype wire
